// ----- rtl/skt_pkg.sv -----
`default_nettype none

package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cmp;
        logic exec;
    } skt_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/skt_ctrl.sv -----
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output skt_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    // The result slot can take a new result when it is empty or is being taken now.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) || ((state_reg == S_EXEC) && out_free));
    assign accept   = in_valid && !in_stall;

    assign cmd.load = accept;
    assign cmd.cmp  = (state_reg == S_CMP);
    assign cmd.exec = (state_reg == S_EXEC) && out_free;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/skt_dpath.sv -----
`default_nettype none

module skt_dpath
    import skt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire skt_cmd_t               cmd,
    input  wire logic [1:0]             kind,
    input  wire logic [KEY_WIDTH-1:0]   key,
    input  wire logic [IDX_W-1:0]       read_index,
    output logic [1:0]                  status,
    output logic [IDX_W-1:0]            position,
    output logic [KEY_WIDTH-1:0]        key_out,
    output logic [CNT_W-1:0]            count
);

    logic [KEY_WIDTH-1:0]   cell_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    kind_t                  req_kind_reg;
    logic [KEY_WIDTH-1:0]   req_key_reg;
    logic [IDX_W-1:0]       req_idx_reg;

    logic [TABLE_DEPTH-1:0] le_reg;
    logic [TABLE_DEPTH-1:0] eq_reg;
    logic [TABLE_DEPTH-1:0] sel_reg;
    logic [TABLE_DEPTH-1:0] le_next;
    logic [TABLE_DEPTH-1:0] eq_next;
    logic [TABLE_DEPTH-1:0] sel_next;

    logic [TABLE_DEPTH-1:0] ins_mask;
    logic [TABLE_DEPTH-1:0] ins_head;
    logic [TABLE_DEPTH-1:0] rem_mask;
    logic [TABLE_DEPTH-1:0] match_head;
    logic [KEY_WIDTH-1:0]   read_data;
    logic                   full;
    logic                   hit;
    logic                   in_range;
    logic                   do_insert;
    logic                   do_remove;

    status_t                status_reg;
    status_t                status_next;
    logic [IDX_W-1:0]       position_reg;
    logic [IDX_W-1:0]       position_next;
    logic [KEY_WIDTH-1:0]   key_out_reg;
    logic [KEY_WIDTH-1:0]   key_out_next;

    function automatic logic [IDX_W-1:0] encode(input logic [TABLE_DEPTH-1:0] vec);
        logic [IDX_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (vec[i])
            begin
                acc = acc | IDX_W'(i);
            end
        end
        return acc;
    endfunction

    // Every cell compares itself against the request key in parallel.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            le_next[i]  = (count_reg > CNT_W'(i)) && (cell_reg[i] <= req_key_reg);
            eq_next[i]  = (count_reg > CNT_W'(i)) && (cell_reg[i] == req_key_reg);
            sel_next[i] = (count_reg > CNT_W'(i)) && (req_idx_reg == IDX_W'(i));
        end
    end

    // The table is sorted, so le is a run of ones from the bottom and the
    // matching cells form one contiguous run.
    always_comb
    begin
        ins_mask      = ~le_reg;
        rem_mask      = ~(le_reg & ~eq_reg);
        ins_head[0]   = ins_mask[0];
        match_head[0] = eq_reg[0];
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            ins_head[i]   = ins_mask[i] && le_reg[i-1];
            match_head[i] = eq_reg[i] && !eq_reg[i-1];
        end
        read_data = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sel_reg[i])
            begin
                read_data = read_data | cell_reg[i];
            end
        end
    end

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit       = |eq_reg;
    assign in_range  = |sel_reg;
    assign do_insert = (req_kind_reg == KIND_INSERT) && !full;
    assign do_remove = (req_kind_reg == KIND_REMOVE) && hit;

    always_comb
    begin
        status_next   = ST_OK;
        position_next = '0;
        key_out_next  = '0;
        count_next    = count_reg;
        case (req_kind_reg)
            KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    position_next = encode(ins_head);
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (hit)
                begin
                    position_next = encode(match_head);
                    count_next    = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            KIND_FIND:
            begin
                if (hit)
                begin
                    position_next = encode(match_head);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            KIND_READ:
            begin
                if (in_range)
                begin
                    key_out_next = read_data;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_kind_reg <= kind_t'(kind);
            req_key_reg  <= key;
            req_idx_reg  <= read_index;
        end
        if (cmd.cmp)
        begin
            le_reg  <= le_next;
            eq_reg  <= eq_next;
            sel_reg <= sel_next;
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            key_out_reg  <= key_out_next;
        end
    end

    // Insert shifts the cells above the insertion point up by one; remove
    // pulls the cells from the match upward down by one.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_insert)
        begin
            if (ins_mask[0])
            begin
                cell_reg[0] <= req_key_reg;
            end
            for (int i = 1; i < TABLE_DEPTH; i++)
            begin
                if (ins_mask[i])
                begin
                    cell_reg[i] <= ins_head[i] ? req_key_reg : cell_reg[i-1];
                end
            end
        end
        else if (cmd.exec && do_remove)
        begin
            for (int i = 0; i < TABLE_DEPTH - 1; i++)
            begin
                if (rem_mask[i])
                begin
                    cell_reg[i] <= cell_reg[i+1];
                end
            end
        end
    end

    assign status   = status_reg;
    assign position = position_reg;
    assign key_out  = key_out_reg;
    assign count    = count_reg;

endmodule

`default_nettype wire

// ----- rtl/sorted_key_table.sv -----
// A request is registered when accepted; a compare step over all cells is then followed
// by an execute step that shifts the cells and loads the result register.
// No request is accepted during a compare step; the next one can be accepted in the
// execute step of its predecessor, when the result slot is free.
// A waiting result does not block the next request from being accepted and compared.
// Reset (rst_n low, asynchronous) empties the table; no clearing pass is needed.
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             kind,
    input  wire logic [KEY_WIDTH-1:0]   key,
    input  wire logic [IDX_W-1:0]       read_index,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  status,
    output logic [IDX_W-1:0]            position,
    output logic [KEY_WIDTH-1:0]        key_out,
    output logic [CNT_W-1:0]            count
);

    skt_cmd_t cmd;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    skt_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (kind),
        .key        (key),
        .read_index (read_index),
        .status     (status),
        .position   (position),
        .key_out    (key_out),
        .count      (count)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (count == CNT_W'(TABLE_DEPTH)))
        else $error("full status with a table that is not full");

    a_compare_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted during its predecessor's compare cycle");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND) |-> (position == '0) && (key_out == '0))
        else $error("miss result carries a position or key");
`endif

endmodule

`default_nettype wire

// ----- bench/sorted_key_table_test.sv -----
`timescale 1ns / 100ps

module sorted_key_table_test;
    import skt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_SIZE  = 125;
    localparam int SEGMENT_COUNT = 14;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        kind_t                 kind;
        logic [KEY_WIDTH-1:0]  key;
        logic [IDX_W-1:0]      index;
    } table_request_t;

    typedef struct packed {
        status_t               status;
        logic [IDX_W-1:0]      position;
        logic [KEY_WIDTH-1:0]  key_out;
        logic [CNT_W-1:0]      count;
    } table_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = KIND_INSERT;
    logic [KEY_WIDTH-1:0]  key = '0;
    logic [IDX_W-1:0]      read_index = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            status;
    logic [IDX_W-1:0]      position;
    logic [KEY_WIDTH-1:0]  key_out;
    logic [CNT_W-1:0]      count;

    table_request_t        pending_requests[$];
    table_result_t         awaited_results[$];
    logic [KEY_WIDTH-1:0]  inserted_keys[$];
    logic [KEY_WIDTH-1:0]  common_keys[8];

    // Copy of the table contents as the block should hold them.
    logic [KEY_WIDTH-1:0]  shadow_keys[TABLE_DEPTH];
    int                    held = 0;

    bit                    request_taken = 1'b0;
    int                    accepted_requests = 0;
    int                    mismatches = 0;
    int                    cycle_count = 0;

    sorted_key_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key        (key),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .position   (position),
        .key_out    (key_out),
        .count      (count)
    );

    always #10 clk = ~clk;

    // Idling is switched off while the accepted-request count runs from 600 up to 799.
    function automatic bit idling_allowed();
        return !(accepted_requests >= 600 && accepted_requests < 800);
    endfunction

    task automatic apply_to_table(input table_request_t req, output table_result_t res);
        int slot;
        int i;
        bit hit;
        res = '0;
        res.status = ST_OK;
        case (req.kind)
            KIND_INSERT:
            begin
                if (held >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    // Equal keys stay ahead of the new one.
                    slot = 0;
                    for (i = 0; i < held; i++)
                        if (shadow_keys[i] <= req.key)
                            slot++;
                    for (i = held; i > slot; i--)
                        shadow_keys[i] = shadow_keys[i - 1];
                    shadow_keys[slot] = req.key;
                    held++;
                    res.position = IDX_W'(slot);
                end
            end
            KIND_REMOVE, KIND_FIND:
            begin
                hit = 1'b0;
                slot = 0;
                for (i = 0; i < held && !hit; i++)
                    if (shadow_keys[i] == req.key)
                    begin
                        hit = 1'b1;
                        slot = i;
                    end
                if (!hit)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.position = IDX_W'(slot);
                    if (req.kind == KIND_REMOVE)
                    begin
                        for (i = slot; i + 1 < held; i++)
                            shadow_keys[i] = shadow_keys[i + 1];
                        held--;
                    end
                end
            end
            default:
            begin
                if (req.index < held)
                    res.key_out = shadow_keys[req.index];
                else
                    res.status = ST_RANGE;
            end
        endcase
        res.count = CNT_W'(held);
    endtask

    task automatic push_request(input kind_t k, input logic [KEY_WIDTH-1:0] v,
                                input logic [IDX_W-1:0] idx);
        table_request_t req;
        req.kind = k;
        req.key = v;
        req.index = idx;
        pending_requests.push_back(req);
    endtask

    // Mode 0 mostly inserts and fills the table, mode 1 mixes all kinds,
    // mode 2 mostly removes keys known to have been inserted.
    task automatic add_random_request(input int mode);
        int r;
        int pick;
        kind_t k;
        logic [KEY_WIDTH-1:0] v;
        r = $urandom_range(0, 99);
        case (mode)
            0: k = r < 75 ? KIND_INSERT : r < 82 ? KIND_REMOVE : r < 90 ? KIND_FIND : KIND_READ;
            1: k = r < 25 ? KIND_INSERT : r < 50 ? KIND_REMOVE : r < 75 ? KIND_FIND : KIND_READ;
            default: k = r < 5 ? KIND_INSERT : r < 85 ? KIND_REMOVE : r < 93 ? KIND_FIND
                                                                      : KIND_READ;
        endcase
        if (k == KIND_INSERT)
        begin
            v = ($urandom_range(0, 99) < 40) ? common_keys[$urandom_range(0, 7)] : $urandom;
            inserted_keys.push_back(v);
        end
        else if (k != KIND_READ && inserted_keys.size() > 0 && $urandom_range(0, 99) < 85)
        begin
            pick = $urandom_range(0, inserted_keys.size() - 1);
            v = inserted_keys[pick];
            if (k == KIND_REMOVE)
                inserted_keys.delete(pick);
        end
        else
            v = $urandom_range(0, 1) ? common_keys[$urandom_range(0, 7)] : $urandom;
        push_request(k, v, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)));
    endtask

    // Driver: presents the head of the pending queue and holds it until taken.
    always @(posedge clk)
    begin
        table_result_t res;
        if (rst_n && in_valid && !in_stall)
        begin
            apply_to_table(pending_requests[0], res);
            awaited_results.push_back(res);
            void'(pending_requests.pop_front());
            accepted_requests++;
            request_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || request_taken))
        begin
            if (pending_requests.size() > 0
                && !(idling_allowed() && $urandom_range(0, 99) < 30))
            begin
                in_valid <= 1'b1;
                kind <= pending_requests[0].kind;
                key <= pending_requests[0].key;
                read_index <= pending_requests[0].index;
            end
            else
                in_valid <= 1'b0;
        end
        request_taken = 1'b0;
    end

    // Monitor: stalls the result side at random and checks every result taken.
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= idling_allowed() && ($urandom_range(0, 99) < 30);
    end

    always @(posedge clk)
    begin
        table_result_t want;
        table_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status_t'(status);
            got.position = position;
            got.key_out = key_out;
            got.count = count;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d position %0d key_out %h count %0d",
                             got.status, got.position, got.key_out, got.count);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: expected status %0d position %0d key_out %h count %0d, got status %0d position %0d key_out %h count %0d",
                                 accepted_requests, want.status, want.position, want.key_out,
                                 want.count, got.status, got.position, got.key_out, got.count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sorted_key_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int n;
        common_keys[0] = '0;
        common_keys[1] = '1;
        common_keys[2] = 32'h8000_0000;
        common_keys[3] = 32'h7FFF_FFFF;
        common_keys[4] = 32'h0000_0001;
        common_keys[5] = $urandom;
        common_keys[6] = $urandom;
        common_keys[7] = $urandom;

        // Empty table: every lookup misses and every read is out of range.
        push_request(KIND_READ, 32'hFFFF_FFFF, '0);
        push_request(KIND_FIND, 32'd5, '0);
        push_request(KIND_REMOVE, 32'd5, '1);
        // Extremes and duplicate keys.
        push_request(KIND_INSERT, 32'hFFFF_FFFF, '1);
        push_request(KIND_INSERT, 32'h0000_0000, '0);
        push_request(KIND_INSERT, 32'h8000_0000, '0);
        push_request(KIND_INSERT, 32'h8000_0000, '0);
        push_request(KIND_INSERT, 32'd7, '0);
        push_request(KIND_INSERT, 32'h8000_0000, '0);
        push_request(KIND_FIND, 32'h8000_0000, '0);
        push_request(KIND_FIND, 32'hFFFF_FFFF, '0);
        push_request(KIND_FIND, 32'd1, '0);
        for (n = 0; n <= 6; n++)
            push_request(KIND_READ, $urandom, IDX_W'(n));
        push_request(KIND_READ, '0, '1);
        push_request(KIND_REMOVE, 32'h8000_0000, '0);
        push_request(KIND_REMOVE, 32'hFFFF_FFFF, '0);
        push_request(KIND_REMOVE, 32'h0000_0000, '0);
        push_request(KIND_REMOVE, 32'd9, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (seg = 0; seg < SEGMENT_COUNT; seg++)
        begin
            if (seg == SEGMENT_COUNT / 2)
            begin
                // Let the block drain completely before going on.
                while (pending_requests.size() > 0 || awaited_results.size() > 0)
                    @(posedge clk);
            end
            for (n = 0; n < SEGMENT_SIZE; n++)
                add_random_request(seg % 3);
        end

        while (pending_requests.size() > 0 || awaited_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("sorted_key_table: match");
        else
            $display("sorted_key_table: mismatch");
        $finish;
    end

endmodule

// ----- sorted_key_table.f -----
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_dpath.sv
rtl/sorted_key_table.sv
bench/sorted_key_table_test.sv
